/* hdl/bat_pkg.sv */
// shared types and codes for the breakpoint address table
package bat_pkg;

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_ADD    = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;
	localparam logic [1:0] REQ_TOGGLE = 2'd3;

	localparam logic [2:0] ST_ADDED    = 3'd0;
	localparam logic [2:0] ST_PRESENT  = 3'd1;
	localparam logic [2:0] ST_REMOVED  = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [2:0] ST_BADADDR  = 3'd5;

	localparam logic [2:0] OP_LOOKUP = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_DELETE = 3'd2;
	localparam logic [2:0] OP_TOGGLE = 3'd3;
	localparam logic [2:0] OP_BAD    = 3'd4;

	localparam int GROUP_W = 32;
	localparam int LOCAL_W = 5;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PW    = 1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] bp_address;
		logic [7:0]  memory_byte;
	} req_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic       was_present;
		logic [7:0] saved_byte;
	} rsp_item_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] addr;
		logic [7:0]  mem_byte;
	} op_t;

endpackage

/* hdl/bat_req_if.sv */
// request channel: valid, ready and one request item
interface bat_req_if;
	logic                valid;
	logic                ready;
	bat_pkg::req_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/bat_rsp_if.sv */
// response channel: valid, ready and one result item
interface bat_rsp_if;
	logic                valid;
	logic                ready;
	bat_pkg::rsp_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/bat_ram.sv */
// generic single write port ram with registered read
module bat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/bat_front.sv */
// front end: accepts request items and classifies them into operations
module bat_front (
	input  logic          clk,
	input  logic          arst_n,
	bat_req_if.sink       req,
	output logic          push_valid,
	input  logic          push_ready,
	output bat_pkg::op_t  push_data
);

	logic         valid_s1;
	bat_pkg::op_t op_s1;
	bat_pkg::op_t op_next;

	assign req.ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = op_s1;

	always_comb begin
		op_next.addr     = req.data.bp_address;
		op_next.mem_byte = req.data.memory_byte;
		unique case (req.data.req_type)
			bat_pkg::REQ_LOOKUP: op_next.op = bat_pkg::OP_LOOKUP;
			bat_pkg::REQ_ADD:    op_next.op = bat_pkg::OP_ADD;
			bat_pkg::REQ_DELETE: op_next.op = bat_pkg::OP_DELETE;
			bat_pkg::REQ_TOGGLE: op_next.op = bat_pkg::OP_TOGGLE;
			default:             op_next.op = bat_pkg::OP_LOOKUP;
		endcase
		// address zero is rejected as a bad address
		if (req.data.bp_address == 32'd0) begin
			op_next.op = bat_pkg::OP_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1 <= op_next;
		end
	end

endmodule

/* hdl/bat_queue.sv */
// short fifo between front end and table engine
module bat_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  bat_pkg::op_t  push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output bat_pkg::op_t  pop_data
);

	bat_pkg::op_t                  slot_q [bat_pkg::QUEUE_DEPTH];
	logic [bat_pkg::QUEUE_PW-1:0]  wr_ptr_q;
	logic [bat_pkg::QUEUE_PW-1:0]  rd_ptr_q;
	logic [bat_pkg::QUEUE_PW:0]    count_q;
	logic                          do_push;
	logic                          do_pop;

	assign push_ready = count_q != (bat_pkg::QUEUE_PW+1)'(bat_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hdl/bat_engine.sv */
// back end: associative match, free entry pick and table update
module bat_engine #(
	parameter int ENTRIES = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  bat_pkg::op_t  pop_data,
	bat_rsp_if.source     rsp
);

	localparam int IW     = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
	localparam int GROUPS = (ENTRIES + bat_pkg::GROUP_W - 1) / bat_pkg::GROUP_W;
	localparam int GIW    = GROUPS > 1 ? $clog2(GROUPS) : 1;
	localparam int CW     = GIW + bat_pkg::LOCAL_W;
	localparam int PADW   = GROUPS * bat_pkg::GROUP_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CMP  = 3'd1;
	localparam logic [2:0] S_GRP  = 3'd2;
	localparam logic [2:0] S_SEL  = 3'd3;
	localparam logic [2:0] S_UPD  = 3'd4;

	logic [2:0]                   state_q;
	bat_pkg::op_t                 cur_q;
	logic [ENTRIES-1:0]           valid_q;
	logic [31:0]                  addr_q [ENTRIES];

	logic [PADW-1:0]              hit_vec_c;
	logic [PADW-1:0]              free_vec_c;
	logic [PADW-1:0]              hit_vec_s1;
	logic [PADW-1:0]              free_vec_s1;
	logic [GROUPS-1:0]            grp_hit_s2;
	logic [GROUPS-1:0]            grp_free_s2;
	logic [bat_pkg::LOCAL_W-1:0]  grp_hit_idx_s2 [GROUPS];
	logic [bat_pkg::LOCAL_W-1:0]  grp_free_idx_s2 [GROUPS];

	logic [GROUPS-1:0]            grp_hit_c;
	logic [GROUPS-1:0]            grp_free_c;
	logic [bat_pkg::LOCAL_W-1:0]  grp_hit_idx_c [GROUPS];
	logic [bat_pkg::LOCAL_W-1:0]  grp_free_idx_c [GROUPS];

	logic                         hit_c;
	logic                         free_c;
	logic [CW-1:0]                hit_idx_c;
	logic [CW-1:0]                free_idx_c;

	logic                         hit_q;
	logic                         free_q;
	logic [IW-1:0]                hit_idx_q;
	logic [IW-1:0]                free_idx_q;

	logic [7:0]                   ram_rdata;
	logic                         out_ok;
	logic                         wr_add;
	logic                         wr_del;
	logic [2:0]                   status_c;

	logic                         out_valid_q;
	bat_pkg::rsp_item_t           out_q;

	assign pop_ready = state_q == S_IDLE;
	assign out_ok    = !out_valid_q || rsp.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// match and free vectors, padding bits stay clear
	always_comb begin
		hit_vec_c  = '0;
		free_vec_c = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec_c[i]  = valid_q[i] && (addr_q[i] == cur_q.addr);
			free_vec_c[i] = !valid_q[i];
		end
	end

	// lowest set bit inside each group
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			grp_hit_c[g]      = 1'b0;
			grp_free_c[g]     = 1'b0;
			grp_hit_idx_c[g]  = '0;
			grp_free_idx_c[g] = '0;
			for (int l = bat_pkg::GROUP_W - 1; l >= 0; l--) begin
				if (hit_vec_s1[g * bat_pkg::GROUP_W + l]) begin
					grp_hit_c[g]     = 1'b1;
					grp_hit_idx_c[g] = bat_pkg::LOCAL_W'(l);
				end
				if (free_vec_s1[g * bat_pkg::GROUP_W + l]) begin
					grp_free_c[g]     = 1'b1;
					grp_free_idx_c[g] = bat_pkg::LOCAL_W'(l);
				end
			end
		end
	end

	// lowest group with a set bit
	always_comb begin
		hit_c      = 1'b0;
		free_c     = 1'b0;
		hit_idx_c  = '0;
		free_idx_c = '0;
		for (int g = GROUPS - 1; g >= 0; g--) begin
			if (grp_hit_s2[g]) begin
				hit_c     = 1'b1;
				hit_idx_c = {GIW'(g), grp_hit_idx_s2[g]};
			end
			if (grp_free_s2[g]) begin
				free_c     = 1'b1;
				free_idx_c = {GIW'(g), grp_free_idx_s2[g]};
			end
		end
	end

	always_comb begin
		status_c = bat_pkg::ST_NOTFOUND;
		wr_add   = 1'b0;
		wr_del   = 1'b0;
		unique case (cur_q.op)
			bat_pkg::OP_BAD: begin
				status_c = bat_pkg::ST_BADADDR;
			end
			bat_pkg::OP_LOOKUP: begin
				status_c = hit_q ? bat_pkg::ST_PRESENT : bat_pkg::ST_NOTFOUND;
			end
			bat_pkg::OP_ADD: begin
				if (hit_q) begin
					status_c = bat_pkg::ST_PRESENT;
				end else if (free_q) begin
					status_c = bat_pkg::ST_ADDED;
					wr_add   = 1'b1;
				end else begin
					status_c = bat_pkg::ST_FULL;
				end
			end
			bat_pkg::OP_DELETE: begin
				if (hit_q) begin
					status_c = bat_pkg::ST_REMOVED;
					wr_del   = 1'b1;
				end
			end
			bat_pkg::OP_TOGGLE: begin
				if (hit_q) begin
					status_c = bat_pkg::ST_REMOVED;
					wr_del   = 1'b1;
				end else if (free_q) begin
					status_c = bat_pkg::ST_ADDED;
					wr_add   = 1'b1;
				end else begin
					status_c = bat_pkg::ST_FULL;
				end
			end
			default: begin
				status_c = bat_pkg::ST_BADADDR;
			end
		endcase
	end

	bat_ram #(
		.WIDTH (8),
		.DEPTH (ENTRIES)
	) u_byte_ram (
		.clk   (clk),
		.we    (state_q == S_UPD && out_ok && wr_add),
		.waddr (free_idx_q),
		.wdata (cur_q.mem_byte),
		.raddr (hit_idx_c[IW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_UPD && out_ok) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_GRP;
				end
				S_GRP: begin
					state_q <= S_SEL;
				end
				S_SEL: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (out_ok) begin
						state_q <= S_IDLE;
						if (wr_add) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						if (wr_del) begin
							valid_q[hit_idx_q] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && pop_valid) begin
			cur_q <= pop_data;
		end
		if (state_q == S_CMP) begin
			hit_vec_s1  <= hit_vec_c;
			free_vec_s1 <= free_vec_c;
		end
		if (state_q == S_GRP) begin
			grp_hit_s2  <= grp_hit_c;
			grp_free_s2 <= grp_free_c;
			for (int g = 0; g < GROUPS; g++) begin
				grp_hit_idx_s2[g]  <= grp_hit_idx_c[g];
				grp_free_idx_s2[g] <= grp_free_idx_c[g];
			end
		end
		if (state_q == S_SEL) begin
			hit_q      <= hit_c;
			free_q     <= free_c;
			hit_idx_q  <= hit_idx_c[IW-1:0];
			free_idx_q <= free_idx_c[IW-1:0];
		end
		if (state_q == S_UPD && out_ok) begin
			out_q.status      <= status_c;
			out_q.was_present <= hit_q && (cur_q.op != bat_pkg::OP_BAD);
			out_q.saved_byte  <= (hit_q && (cur_q.op != bat_pkg::OP_BAD)) ? ram_rdata : 8'd0;
			if (wr_add) begin
				addr_q[free_idx_q] <= cur_q.addr;
			end
		end
	end

endmodule

/* hdl/breakpoint_address_table.sv */
// top level of the breakpoint address table
//
// channel  dir  payload                                   handshake
// req      in   req_type, bp_address, memory_byte        valid/ready
// rsp      out  status, was_present, saved_byte           valid/ready
//
// the table engine steps through pop, compare, group pick, final pick with byte
// ram read, and update; it takes a new item only after the update of the last one.
// reset clears every valid bit at once; entries need no clearing pass.
// a stalled rsp holds the engine in its update step while the front register
// and the 2-entry queue keep taking up to 3 more items.
module breakpoint_address_table #(
	parameter int ENTRIES = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	bat_req_if.sink    req,
	bat_rsp_if.source  rsp
);

	logic          push_valid;
	logic          push_ready;
	bat_pkg::op_t  push_data;
	logic          pop_valid;
	logic          pop_ready;
	bat_pkg::op_t  pop_data;

	bat_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	bat_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	bat_engine #(
		.ENTRIES (ENTRIES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.rsp       (rsp)
	);

endmodule
